/* design/assert_macros.svh */
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication, disabled while rst_n is low
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);
// Assert a plain condition at every edge
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) cond) else $error(msg);
`endif

/* design/dhfi_pkg.sv */
// Package with shared types and constants of the double-hash find-or-insert block
package dhfi_pkg;
    localparam int unsigned KEY_W  = 48;
    localparam int unsigned SIZE_W = 13;
    localparam int unsigned SLOT_W = 12;
    localparam int unsigned STAT_W = 2;

    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture key, start reductions
        logic div_step;  // one bit of the two modulo reductions
        logic setup;     // turn remainders into home slot and step
        logic clr_step;  // one entry of the clearing pass
        logic rd;        // issue a key store read at the current slot
        logic wr;        // store the key at the current slot
        logic adv;       // move to the next probe slot
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic key_zero;
        logic div_done;
        logic clr_done;
        logic hit_empty;
        logic hit_match;
        logic probes_done;
    } t_dp_sts;
endpackage

/* design/double_hash_find_or_insert.sv */
// Top level: double-hash find-or-insert over an open-addressed key table
// Throughput: one transaction at a time; the input stalls while a key is reduced
// bit-serially over 48 key bits and probed through the single key store read port.
// Reset: clearing pass over SLOTS entries, one per cycle, input stalled meanwhile.
// table_size resets to 4093 and may be written at any time while idle.
module double_hash_find_or_insert #(
    parameter int unsigned SLOTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dhfi_pkg::KEY_W-1:0]  i_key,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dhfi_pkg::SLOT_W-1:0] o_slot,
    output logic [dhfi_pkg::STAT_W-1:0] o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dhfi_pkg::SIZE_W-1:0] i_cfg_data
);
    import dhfi_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);

    logic [SIZE_W-1:0] r_table_size;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [AW-1:0]     pos;
    logic [AW-1:0]     slot;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_W'(4093);
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    dhfi_datapath #(.SLOTS(SLOTS), .AW(AW)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_table_size (r_table_size),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_pos        (pos)
    );

    dhfi_ctrl #(.AW(AW)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_slot   (slot),
        .o_status (o_status),
        .i_sts    (sts),
        .i_pos    (pos),
        .o_cmd    (cmd)
    );

    assign o_slot = SLOT_W'(slot);
endmodule

/* design/dhfi_datapath.sv */
// Datapath: modulo reducers, probe address logic and the key store memory
module dhfi_datapath #(
    parameter int unsigned SLOTS = 4096,
    parameter int unsigned AW    = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [dhfi_pkg::KEY_W-1:0]  i_key,
    input  logic [dhfi_pkg::SIZE_W-1:0] i_table_size,
    input  dhfi_pkg::t_dp_cmd         i_cmd,
    output dhfi_pkg::t_dp_sts         o_sts,
    output logic [AW-1:0]             o_pos
);
    import dhfi_pkg::*;

    localparam int unsigned NW = AW + 1;
    localparam int unsigned CW = $clog2(KEY_W + 1);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_code;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_rem_a, r_rem_b;
    logic [CW-1:0]    r_bit;
    logic [AW-1:0]    r_pos;
    logic [NW-1:0]    r_stepv;
    logic [NW-1:0]    r_probes;
    logic [AW-1:0]    r_clr;
    logic             r_clr_done;
    logic [KEY_W-1:0] r_rd;
    logic [KEY_W-1:0] mem [SLOTS];

    logic [NW-1:0] n_eff;
    logic [NW:0]   sh_a, sh_b;
    logic [NW:0]   nxt;
    logic          cbit;

    // Clamp configured size into 3..SLOTS
    always_comb begin
        if (i_table_size < SIZE_W'(3)) begin
            n_eff = NW'(3);
        end else if ({{(32-SIZE_W){1'b0}}, i_table_size} > SLOTS) begin
            n_eff = NW'(SLOTS);
        end else begin
            n_eff = NW'(i_table_size);
        end
    end

    // Restoring remainder, one code bit a cycle, both divisors
    assign cbit = r_code[KEY_W-1];
    assign sh_a = {r_rem_a, cbit};
    assign sh_b = {r_rem_b, cbit};
    assign nxt  = {1'b0, r_pos} + {1'b0, r_stepv};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_code  <= i_key - KEY_W'(1);
            r_n     <= n_eff;
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_bit   <= '0;
        end else if (i_cmd.div_step) begin
            r_code  <= {r_code[KEY_W-2:0], 1'b0};
            r_bit   <= r_bit + CW'(1);
            r_rem_a <= (sh_a >= {1'b0, r_n}) ? NW'(sh_a - {1'b0, r_n}) : NW'(sh_a);
            r_rem_b <= (sh_b >= {1'b0, r_n} - (NW+1)'(1))
                     ? NW'(sh_b - ({1'b0, r_n} - (NW+1)'(1))) : NW'(sh_b);
        end
        if (i_cmd.setup) begin
            r_pos    <= AW'(r_rem_a);
            r_stepv  <= r_rem_b + NW'(1);
            r_probes <= '0;
        end else if (i_cmd.adv) begin
            r_pos    <= (nxt >= {1'b0, r_n}) ? AW'(nxt - {1'b0, r_n}) : AW'(nxt);
            r_probes <= r_probes + NW'(1);
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
            if (r_clr == AW'(SLOTS - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // Key store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr] <= '0;
        end else if (i_cmd.wr) begin
            mem[r_pos] <= r_key;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_pos];
        end
    end

    assign o_sts.key_zero    = (r_key == '0);
    assign o_sts.div_done    = (r_bit == CW'(KEY_W));
    assign o_sts.clr_done    = r_clr_done;
    assign o_sts.hit_empty   = (r_rd == '0);
    assign o_sts.hit_match   = (r_rd == r_key);
    assign o_sts.probes_done = (r_probes + NW'(1) >= r_n);
    assign o_pos             = r_pos;
endmodule

/* design/dhfi_ctrl.sv */
// Controller: sequences clearing, reduction, probing and result hand-off
module dhfi_ctrl #(
    parameter int unsigned AW = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [AW-1:0]               o_slot,
    output logic [dhfi_pkg::STAT_W-1:0] o_status,
    input  dhfi_pkg::t_dp_sts           i_sts,
    input  logic [AW-1:0]               i_pos,
    output dhfi_pkg::t_dp_cmd           o_cmd
);
    import dhfi_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_SETUP, S_READ, S_EVAL
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic [AW-1:0]     r_slot, n_slot;
    logic [STAT_W-1:0] r_status, n_status;
    logic   out_free;

    assign out_free = !r_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid && i_stall;
        n_slot   = r_slot;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = !i_sts.clr_done;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.key_zero) begin
                    if (out_free) begin
                        n_valid  = 1'b1;
                        n_slot   = '0;
                        n_status = ST_FULL;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_SETUP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.hit_empty || i_sts.hit_match || i_sts.probes_done) begin
                    if (out_free) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (i_sts.hit_empty) begin
                            o_cmd.wr = 1'b1;
                            n_slot   = i_pos;
                            n_status = ST_INSERTED;
                        end else if (i_sts.hit_match) begin
                            n_slot   = i_pos;
                            n_status = ST_FOUND;
                        end else begin
                            n_slot   = '0;
                            n_status = ST_FULL;
                        end
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_slot   = r_slot;
    assign o_status = r_status;
endmodule

/* design/dhfi_checker.sv */
// Port-level checker for the find-or-insert block, bound to the top level
`include "assert_macros.svh"
module dhfi_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [dhfi_pkg::STAT_W-1:0] o_status,
    input logic [dhfi_pkg::SLOT_W-1:0] o_slot
);
    import dhfi_pkg::*;

    `ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status != 2'd3), "bad status")
    `ASSERT_IMPL(a_full_slot0, i_clk, i_rst_n,
        (o_valid && o_status == ST_FULL) |-> (o_slot == '0), "full with slot")
    `ASSERT_IMPL(a_busy_after_take, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> o_stall, "took two items back to back")
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_slot) && $stable(o_status)),
        "stalled result changed")
endmodule

bind double_hash_find_or_insert dhfi_checker u_chk (.*);
